// File: rtl/core/gsb_pkg.sv
package gsb_pkg;

  // Field widths and fixed-point format
  localparam int CW     = 32;
  localparam int FB     = 20;
  localparam int EPS_W  = 21;
  localparam int VAL_W  = 64;
  localparam int HALF   = VAL_W / 2;
  localparam int MAG_W  = 62;
  localparam int PW     = 2 * VAL_W;

  // Root and quotient datapath sizes
  localparam int RAD_W  = MAG_W + FB;
  localparam int SQ_N   = RAD_W / 2;
  localparam int SQR_W  = SQ_N + 3;
  localparam int DR_W   = 2 * CW + 3;
  localparam int VW     = SQ_N + 1;
  localparam int NL     = 5;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic ov;
    val_t v;
  } res_t;

  // Partial products of one magnitude multiply
  typedef struct packed {
    logic [VAL_W-1:0] p00;
    logic [VAL_W-1:0] p01;
    logic [VAL_W-1:0] p10;
    logic [VAL_W-1:0] p11;
    logic             neg;
  } pp_t;

  // Payload of the coefficient stages
  typedef struct packed {
    logic signed [CW-1:0] s;
    logic signed [CW-1:0] e;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y2;
    logic [CW-2:0]        d1;
    logic [CW-2:0]        d2;
    val_t                 alpha;
    val_t                 beta;
    pp_t [5:0]            pp;
    val_t                 m0;
    val_t                 m1;
    val_t                 m2;
    val_t                 m3;
    val_t                 m4;
    val_t                 m5;
    val_t                 n1;
    val_t                 n2;
    val_t                 a;
    val_t                 gamma;
    val_t                 b;
    val_t                 c;
    logic                 ov;
    logic [2*CW+1:0]      qs1;
    logic [2*CW+1:0]      qe1;
    logic [2*CW+1:0]      qs2;
    logic [2*CW+1:0]      qe2;
    logic [2*CW-1:0]      y1q;
    logic [2*CW-1:0]      y2q;
    logic [DR_W-1:0]      rs1;
    logic [DR_W-1:0]      re1;
    logic [DR_W-1:0]      rs2;
    logic [DR_W-1:0]      re2;
  } front_t;

  // Side data carried through the root stages
  typedef struct packed {
    logic signed [CW-1:0] s;
    logic signed [CW-1:0] e;
    logic [CW-2:0]        d1;
    logic [CW-2:0]        d2;
    val_t                 a;
    val_t                 b;
    val_t                 c;
    logic                 cond;
    logic                 lin;
  } sd_t;

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [SQR_W-1:0] rem;
    logic [SQ_N-1:0]  root;
  } lane_t;

  typedef struct packed {
    sd_t            sd;
    lane_t [NL-1:0] ln;
  } sq_t;

  // Divider stage payload
  typedef struct packed {
    logic signed [CW-1:0] s;
    logic signed [CW-1:0] e;
    logic                 cond;
    logic                 dov;
    logic                 neg;
    logic [VW-1:0]        v1s;
    logic [VW-1:0]        v2s;
    logic [VW-1:0]        v1e;
    logic [VW-1:0]        v2e;
    logic [RAD_W-1:0]     n;
    logic [MAG_W-1:0]     rem;
    logic [RAD_W-1:0]     q;
    logic [MAG_W-1:0]     d;
  } dv_t;

  function automatic logic [VAL_W-1:0] mag_f(val_t v);
    return v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
  endfunction

  // Saturation check on a sum of two values
  function automatic res_t add_q(val_t u, val_t v);
    val_t             s;
    logic [VAL_W-1:0] m;
    res_t             r;
    s    = u + v;
    m    = mag_f(s);
    r.ov = |m[VAL_W-1:MAG_W];
    r.v  = s;
    return r;
  endfunction

  // First half of a fixed-point multiply: four half-width products
  function automatic pp_t mul_pp(val_t u, val_t v);
    logic [VAL_W-1:0] mu;
    logic [VAL_W-1:0] mv;
    logic [HALF-1:0]  a0, a1, b0, b1;
    pp_t              r;
    mu    = mag_f(u);
    mv    = mag_f(v);
    a0    = mu[HALF-1:0];
    a1    = mu[VAL_W-1:HALF];
    b0    = mv[HALF-1:0];
    b1    = mv[VAL_W-1:HALF];
    r.p00 = a0 * b0;
    r.p01 = a0 * b1;
    r.p10 = a1 * b0;
    r.p11 = a1 * b1;
    r.neg = u[VAL_W-1] ^ v[VAL_W-1];
    return r;
  endfunction

  // Second half: sum, scale down with floor, range check
  function automatic res_t mul_fin(pp_t p);
    logic [PW-1:0]    s;
    logic [PW-FB-1:0] q;
    res_t             r;
    s    = PW'(p.p00) + (PW'(p.p01) << HALF) + (PW'(p.p10) << HALF)
         + (PW'(p.p11) << VAL_W);
    q    = s[PW-1:FB] + (PW-FB)'(p.neg & (|s[FB-1:0]));
    r.ov = |q[PW-FB-1:MAG_W];
    r.v  = p.neg ? -val_t'(q[MAG_W-1:0]) : val_t'(q[MAG_W-1:0]);
    return r;
  endfunction

  function automatic logic [2*CW+1:0] dsq(logic signed [CW-1:0] p,
                                          logic signed [CW-1:0] t);
    logic signed [CW:0] dx;
    logic [CW:0]        m;
    dx = {p[CW-1], p} - {t[CW-1], t};
    m  = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
    return m * m;
  endfunction

  function automatic logic [2*CW-1:0] ysq(logic signed [CW-1:0] y);
    logic [CW-1:0] m;
    m = y[CW-1] ? CW'(-y) : CW'(y);
    return m * m;
  endfunction

  // One digit of the integer square root
  function automatic lane_t sq_step(lane_t l);
    logic [SQR_W-1:0] r2;
    logic [SQR_W-1:0] tr;
    lane_t            o;
    r2    = {l.rem[SQR_W-3:0], l.rad[RAD_W-1 -: 2]};
    tr    = {1'b0, l.root, 2'b01};
    o.rad = {l.rad[RAD_W-3:0], 2'b00};
    if (r2 >= tr) begin
      o.rem  = r2 - tr;
      o.root = {l.root[SQ_N-2:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {l.root[SQ_N-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic sq_t sq_stage(sq_t i);
    sq_t o;
    o = i;
    for (int k = 0; k < NL; k++) begin
      o.ln[k] = sq_step(i.ln[k]);
    end
    return o;
  endfunction

  // One bit of the restoring divider
  function automatic dv_t dv_step(dv_t i);
    logic [MAG_W:0] r2;
    logic [MAG_W:0] df;
    logic           ge;
    dv_t            o;
    o     = i;
    r2    = {i.rem, i.n[RAD_W-1]};
    df    = r2 - {1'b0, i.d};
    ge    = (r2 >= {1'b0, i.d});
    o.rem = ge ? df[MAG_W-1:0] : r2[MAG_W-1:0];
    o.q   = {i.q[RAD_W-2:0], ge};
    o.n   = {i.n[RAD_W-2:0], 1'b0};
    return o;
  endfunction

endpackage

// File: rtl/core/geodesic_source_bisector.sv
// The first piece strobes once a transaction has passed 11 coefficient stages, 41 root-digit
// stages, 82 divider-bit stages and the output register, a second piece in the cycle after
// the first. Throughput: one transaction per cycle while busy is low.
// A transaction that splits holds busy high for one cycle while its second piece is loaded into the output registers.
// Reset (synchronous, rst_n low) clears all valid bits, the pending piece and the strobe,
// and sets eps to 1.
module geodesic_source_bisector (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [gsb_pkg::CW-1:0]      in_seg_start,
  input  logic signed [gsb_pkg::CW-1:0]      in_seg_end,
  input  logic signed [gsb_pkg::CW-1:0]      in_src1_x,
  input  logic signed [gsb_pkg::CW-1:0]      in_src1_y,
  input  logic [gsb_pkg::CW-2:0]             in_src1_dist,
  input  logic signed [gsb_pkg::CW-1:0]      in_src2_x,
  input  logic signed [gsb_pkg::CW-1:0]      in_src2_y,
  input  logic [gsb_pkg::CW-2:0]             in_src2_dist,
  output logic                               out_strobe,
  output logic signed [gsb_pkg::CW-1:0]      out_piece_start,
  output logic signed [gsb_pkg::CW-1:0]      out_piece_end,
  output logic                               out_owner,
  output logic                               out_last_piece,
  input  logic                               cfg_we,
  input  logic [gsb_pkg::EPS_W-1:0]          cfg_wdata
);
  import gsb_pkg::*;

  localparam int NF = 11;
  localparam int NV = NF + SQ_N + RAD_W + 2;

  logic [EPS_W-1:0] eps_r;
  logic             pend_r;
  logic             adv;
  logic [NV-1:0]    vld_r;

  front_t fr_r   [NF];
  front_t fr_nxt [NF];
  sq_t    sq_r   [SQ_N+1];
  sq_t    sq_in;
  dv_t    dv_r   [RAD_W+1];
  dv_t    dv_in;

  logic                 split_c, first_c, own_c;
  val_t                 x_c;
  logic                 out_strobe_r, out_owner_r, out_last_r;
  logic signed [CW-1:0] out_start_r, out_end_r;
  logic signed [CW-1:0] pend_start_r, pend_end_r;
  logic                 pend_owner_r;

  assign adv  = !pend_r;
  assign busy = pend_r;

  // Tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_W'(1);
    end else if (cfg_we) begin
      eps_r <= cfg_wdata;
    end
  end

  // Coefficient stages: multiplies take a partial-product stage and a sum stage
  always_comb begin : c_front
    res_t r0, r1, r2, r3, r4, r5;
    // stage 0: capture, edge-relative offsets
    fr_nxt[0]       = '0;
    fr_nxt[0].s     = in_seg_start;
    fr_nxt[0].e     = in_seg_end;
    fr_nxt[0].x1    = in_src1_x;
    fr_nxt[0].y1    = in_src1_y;
    fr_nxt[0].d1    = in_src1_dist;
    fr_nxt[0].x2    = in_src2_x;
    fr_nxt[0].y2    = in_src2_y;
    fr_nxt[0].d2    = in_src2_dist;
    fr_nxt[0].alpha = val_t'(in_src2_x) - val_t'(in_src1_x);
    fr_nxt[0].beta  = val_t'({1'b0, in_src2_dist}) - val_t'({1'b0, in_src1_dist});
    // stage 1: squares, edge distance squares
    fr_nxt[1]       = fr_r[0];
    fr_nxt[1].pp[0] = mul_pp(fr_r[0].beta, fr_r[0].beta);
    fr_nxt[1].pp[1] = mul_pp(val_t'(fr_r[0].x1), val_t'(fr_r[0].x1));
    fr_nxt[1].pp[2] = mul_pp(val_t'(fr_r[0].y1), val_t'(fr_r[0].y1));
    fr_nxt[1].pp[3] = mul_pp(val_t'(fr_r[0].x2), val_t'(fr_r[0].x2));
    fr_nxt[1].pp[4] = mul_pp(val_t'(fr_r[0].y2), val_t'(fr_r[0].y2));
    fr_nxt[1].pp[5] = mul_pp(fr_r[0].alpha, fr_r[0].alpha);
    fr_nxt[1].qs1   = dsq(fr_r[0].x1, fr_r[0].s);
    fr_nxt[1].qe1   = dsq(fr_r[0].x1, fr_r[0].e);
    fr_nxt[1].qs2   = dsq(fr_r[0].x2, fr_r[0].s);
    fr_nxt[1].qe2   = dsq(fr_r[0].x2, fr_r[0].e);
    fr_nxt[1].y1q   = ysq(fr_r[0].y1);
    fr_nxt[1].y2q   = ysq(fr_r[0].y2);
    // stage 2
    r0 = mul_fin(fr_r[1].pp[0]);
    r1 = mul_fin(fr_r[1].pp[1]);
    r2 = mul_fin(fr_r[1].pp[2]);
    r3 = mul_fin(fr_r[1].pp[3]);
    r4 = mul_fin(fr_r[1].pp[4]);
    r5 = mul_fin(fr_r[1].pp[5]);
    fr_nxt[2]     = fr_r[1];
    fr_nxt[2].m0  = r0.v;
    fr_nxt[2].m1  = r1.v;
    fr_nxt[2].m2  = r2.v;
    fr_nxt[2].m3  = r3.v;
    fr_nxt[2].m4  = r4.v;
    fr_nxt[2].m5  = r5.v;
    fr_nxt[2].ov  = fr_r[1].ov | r0.ov | r1.ov | r2.ov | r3.ov | r4.ov | r5.ov;
    fr_nxt[2].rs1 = DR_W'(fr_r[1].qs1) + DR_W'(fr_r[1].y1q);
    fr_nxt[2].re1 = DR_W'(fr_r[1].qe1) + DR_W'(fr_r[1].y1q);
    fr_nxt[2].rs2 = DR_W'(fr_r[1].qs2) + DR_W'(fr_r[1].y2q);
    fr_nxt[2].re2 = DR_W'(fr_r[1].qe2) + DR_W'(fr_r[1].y2q);
    // stage 3: norms, leading coefficient
    r0 = add_q(fr_r[2].m1, fr_r[2].m2);
    r1 = add_q(fr_r[2].m3, fr_r[2].m4);
    r2 = add_q(fr_r[2].m5, -fr_r[2].m0);
    fr_nxt[3]    = fr_r[2];
    fr_nxt[3].n1 = r0.v;
    fr_nxt[3].n2 = r1.v;
    fr_nxt[3].a  = r2.v;
    fr_nxt[3].ov = fr_r[2].ov | r0.ov | r1.ov | r2.ov;
    // stage 4: gamma
    r0 = add_q(fr_r[3].n1, -fr_r[3].n2);
    r1 = add_q(r0.v, -fr_r[3].m0);
    fr_nxt[4]       = fr_r[3];
    fr_nxt[4].gamma = r1.v;
    fr_nxt[4].ov    = fr_r[3].ov | r0.ov | r1.ov;
    // stage 5
    fr_nxt[5]       = fr_r[4];
    fr_nxt[5].pp[0] = mul_pp(val_t'(fr_r[4].x2), fr_r[4].m0);
    fr_nxt[5].pp[1] = mul_pp(fr_r[4].gamma, fr_r[4].alpha);
    fr_nxt[5].pp[2] = mul_pp(fr_r[4].gamma, fr_r[4].gamma);
    fr_nxt[5].pp[3] = mul_pp(fr_r[4].n2, fr_r[4].m0);
    // stage 6
    r0 = mul_fin(fr_r[5].pp[0]);
    r1 = mul_fin(fr_r[5].pp[1]);
    r2 = mul_fin(fr_r[5].pp[2]);
    r3 = mul_fin(fr_r[5].pp[3]);
    fr_nxt[6]    = fr_r[5];
    fr_nxt[6].m0 = r0.v;
    fr_nxt[6].m1 = r1.v;
    fr_nxt[6].m2 = r2.v;
    fr_nxt[6].m3 = r3.v;
    fr_nxt[6].ov = fr_r[5].ov | r0.ov | r1.ov | r2.ov | r3.ov;
    // stage 7: b and c (quarter of gamma squared is an arithmetic shift)
    r0 = add_q(fr_r[6].m0, fr_r[6].m0);
    r1 = add_q(fr_r[6].m1, r0.v);
    r2 = add_q(fr_r[6].m2 >>> 2, -fr_r[6].m3);
    fr_nxt[7]    = fr_r[6];
    fr_nxt[7].b  = r1.v;
    fr_nxt[7].c  = r2.v;
    fr_nxt[7].ov = fr_r[6].ov | r0.ov | r1.ov | r2.ov;
    // stage 8
    fr_nxt[8]       = fr_r[7];
    fr_nxt[8].pp[0] = mul_pp(fr_r[7].a, fr_r[7].c);
    fr_nxt[8].pp[1] = mul_pp(fr_r[7].b, fr_r[7].b);
    // stage 9
    r0 = mul_fin(fr_r[8].pp[0]);
    r1 = mul_fin(fr_r[8].pp[1]);
    fr_nxt[9]    = fr_r[8];
    fr_nxt[9].m0 = r0.v;
    fr_nxt[9].m1 = r1.v;
    fr_nxt[9].ov = fr_r[8].ov | r0.ov | r1.ov;
    // stage 10: four times a*c
    r0 = add_q(fr_r[9].m0, fr_r[9].m0);
    r1 = add_q(r0.v, r0.v);
    fr_nxt[10]    = fr_r[9];
    fr_nxt[10].m0 = r1.v;
    fr_nxt[10].ov = fr_r[9].ov | r0.ov | r1.ov;
  end

  // Discriminant, branch flags, root lanes
  always_comb begin : c_sq_in
    res_t             rd;
    logic             ovt;
    logic [VAL_W-1:0] am, bm, cm;
    rd  = add_q(fr_r[NF-1].m1, -fr_r[NF-1].m0);
    ovt = fr_r[NF-1].ov | rd.ov;
    am  = mag_f(fr_r[NF-1].a);
    bm  = mag_f(fr_r[NF-1].b);
    cm  = mag_f(fr_r[NF-1].c);
    sq_in.sd.s    = fr_r[NF-1].s;
    sq_in.sd.e    = fr_r[NF-1].e;
    sq_in.sd.d1   = fr_r[NF-1].d1;
    sq_in.sd.d2   = fr_r[NF-1].d2;
    sq_in.sd.a    = fr_r[NF-1].a;
    sq_in.sd.b    = fr_r[NF-1].b;
    sq_in.sd.c    = fr_r[NF-1].c;
    sq_in.sd.cond = !ovt && !rd.v[VAL_W-1]
                  && !((bm < VAL_W'(eps_r)) && (cm < VAL_W'(eps_r)));
    sq_in.sd.lin  = (am < VAL_W'(eps_r));
    for (int k = 0; k < NL; k++) begin
      sq_in.ln[k].rem  = '0;
      sq_in.ln[k].root = '0;
    end
    sq_in.ln[0].rad = {rd.v[MAG_W-1:0], {FB{1'b0}}};
    sq_in.ln[1].rad = RAD_W'(fr_r[NF-1].rs1);
    sq_in.ln[2].rad = RAD_W'(fr_r[NF-1].rs2);
    sq_in.ln[3].rad = RAD_W'(fr_r[NF-1].re1);
    sq_in.ln[4].rad = RAD_W'(fr_r[NF-1].re2);
  end

  // Numerator and denominator of the root, edge distances
  always_comb begin : c_dv_in
    res_t             rq, rdn;
    val_t             sqv, numv, denv;
    logic [VAL_W-1:0] nm, dm;
    sqv = val_t'(sq_r[SQ_N].ln[0].root);
    rq  = add_q(-sq_r[SQ_N].sd.b, sq_r[SQ_N].sd.a[VAL_W-1] ? -sqv : sqv);
    rdn = add_q(sq_r[SQ_N].sd.a, sq_r[SQ_N].sd.a);
    if (sq_r[SQ_N].sd.lin) begin
      numv      = -sq_r[SQ_N].sd.c;
      denv      = sq_r[SQ_N].sd.b;
      dv_in.dov = (denv == '0);
    end else begin
      numv      = rq.v;
      denv      = rdn.v;
      dv_in.dov = rq.ov | rdn.ov | (denv == '0);
    end
    nm         = mag_f(numv);
    dm         = mag_f(denv);
    dv_in.s    = sq_r[SQ_N].sd.s;
    dv_in.e    = sq_r[SQ_N].sd.e;
    dv_in.cond = sq_r[SQ_N].sd.cond;
    dv_in.neg  = numv[VAL_W-1] ^ denv[VAL_W-1];
    dv_in.v1s  = VW'(sq_r[SQ_N].ln[1].root) + VW'(sq_r[SQ_N].sd.d1);
    dv_in.v2s  = VW'(sq_r[SQ_N].ln[2].root) + VW'(sq_r[SQ_N].sd.d2);
    dv_in.v1e  = VW'(sq_r[SQ_N].ln[3].root) + VW'(sq_r[SQ_N].sd.d1);
    dv_in.v2e  = VW'(sq_r[SQ_N].ln[4].root) + VW'(sq_r[SQ_N].sd.d2);
    dv_in.n    = {nm[MAG_W-1:0], {FB{1'b0}}};
    dv_in.rem  = '0;
    dv_in.q    = '0;
    dv_in.d    = dm[MAG_W-1:0];
  end

  // Split point, owners
  always_comb begin : c_final
    logic             xov, near;
    logic signed [VW:0] dd;
    logic [VW:0]      ddm;
    xov     = dv_r[RAD_W].dov | (|dv_r[RAD_W].q[RAD_W-1:MAG_W]);
    x_c     = dv_r[RAD_W].neg ? -val_t'(dv_r[RAD_W].q[MAG_W-1:0])
                              : val_t'(dv_r[RAD_W].q[MAG_W-1:0]);
    split_c = dv_r[RAD_W].cond && !xov && (x_c > val_t'(dv_r[RAD_W].s))
              && (x_c < val_t'(dv_r[RAD_W].e));
    first_c = !(dv_r[RAD_W].v1s < dv_r[RAD_W].v2s);
    dd      = $signed({1'b0, dv_r[RAD_W].v1s}) - $signed({1'b0, dv_r[RAD_W].v2s});
    ddm     = dd[VW] ? (VW+1)'(-dd) : (VW+1)'(dd);
    near    = (ddm < (VW+1)'(eps_r));
    own_c   = near ? (dv_r[RAD_W].v2e < dv_r[RAD_W].v1e)
                   : (dv_r[RAD_W].v2s < dv_r[RAD_W].v1s);
  end

  // Valid bits travel alongside the payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NV-2:0], start};
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      fr_r     <= fr_nxt;
      sq_r[0]  <= sq_in;
      dv_r[0]  <= dv_in;
    end
  end

  for (genvar j = 1; j <= SQ_N; j++) begin : g_sq
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[j] <= sq_stage(sq_r[j-1]);
      end
    end
  end

  for (genvar j = 1; j <= RAD_W; j++) begin : g_dv
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[j] <= dv_step(dv_r[j-1]);
      end
    end
  end

  // Output control: second piece of a split goes out on the following cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
      pend_r       <= 1'b0;
    end else if (pend_r) begin
      out_strobe_r <= 1'b1;
      pend_r       <= 1'b0;
    end else begin
      out_strobe_r <= vld_r[NV-1];
      pend_r       <= vld_r[NV-1] & split_c;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (pend_r) begin
      out_start_r <= pend_start_r;
      out_end_r   <= pend_end_r;
      out_owner_r <= pend_owner_r;
      out_last_r  <= 1'b1;
    end else if (vld_r[NV-1]) begin
      out_start_r  <= dv_r[RAD_W].s;
      out_end_r    <= split_c ? x_c[CW-1:0] : dv_r[RAD_W].e;
      out_owner_r  <= split_c ? first_c : own_c;
      out_last_r   <= !split_c;
      pend_start_r <= x_c[CW-1:0];
      pend_end_r   <= dv_r[RAD_W].e;
      pend_owner_r <= !first_c;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_piece_start = out_start_r;
  assign out_piece_end   = out_end_r;
  assign out_owner       = out_owner_r;
  assign out_last_piece  = out_last_r;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import gsb_pkg::*;

  localparam int  CYCLE_LIMIT = 400000;
  localparam int  DRAIN_WAIT  = 160;
  localparam longint VLIM     = 64'sh4000_0000_0000_0000;

  typedef struct {
    logic signed [CW-1:0] seg_s;
    logic signed [CW-1:0] seg_e;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic [CW-2:0]        d1;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y2;
    logic [CW-2:0]        d2;
  } query_t;

  typedef struct {
    logic signed [CW-1:0] p_start;
    logic signed [CW-1:0] p_end;
    logic                 owner;
    logic                 last;
  } piece_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] in_seg_start = '0, in_seg_end = '0;
  logic signed [CW-1:0] in_src1_x = '0, in_src1_y = '0, in_src2_x = '0, in_src2_y = '0;
  logic [CW-2:0] in_src1_dist = '0, in_src2_dist = '0;
  logic out_strobe, out_owner, out_last_piece;
  logic signed [CW-1:0] out_piece_start, out_piece_end;
  logic cfg_we = 1'b0;
  logic [EPS_W-1:0] cfg_wdata = '0;

  query_t     pending_q[$];
  piece_t     piece_q[$];
  logic [EPS_W-1:0] tol_eps = 1;
  int         gap_left = 0;
  bit         no_gaps = 0;
  int         n_fail = 0, n_queries = 0, n_splits = 0, n_pieces = 0, cyc = 0;

  geodesic_source_bisector u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_seg_start(in_seg_start), .in_seg_end(in_seg_end),
    .in_src1_x(in_src1_x), .in_src1_y(in_src1_y), .in_src1_dist(in_src1_dist),
    .in_src2_x(in_src2_x), .in_src2_y(in_src2_y), .in_src2_dist(in_src2_dist),
    .out_strobe(out_strobe), .out_piece_start(out_piece_start),
    .out_piece_end(out_piece_end), .out_owner(out_owner),
    .out_last_piece(out_last_piece), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Queue helpers: append at the tail
  function automatic void enqueue_query(query_t q);
    pending_q.insert(pending_q.size(), q);
  endfunction

  function automatic void expect_piece(piece_t p);
    piece_q.insert(piece_q.size(), p);
  endfunction

  // Fixed-point arithmetic with saturation flag
  function automatic logic [63:0] umag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint fit(logic [63:0] m, bit neg, inout bit ov);
    if (m >= 64'(VLIM)) begin
      ov = 1;
      return 0;
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint mulq(longint u, longint v, inout bit ov);
    logic [127:0] p;
    logic [63:0]  q;
    bit           neg;
    neg = (u < 0) != (v < 0);
    p   = {64'b0, umag(u)} * {64'b0, umag(v)};
    q   = p[FB+63:FB];
    if (p[127:FB+64] != 0) begin
      ov = 1;
      return 0;
    end
    if (neg && p[FB-1:0] != 0) q = q + 64'd1;
    return fit(q, neg, ov);
  endfunction

  function automatic longint addq(longint u, longint v, inout bit ov);
    longint s;
    s = u + v;
    return fit(umag(s), s < 0, ov);
  endfunction

  function automatic longint quarter(longint g);
    if (g >= 0) return g / 4;
    return -longint'((umag(g) + 3) / 4);
  endfunction

  function automatic longint divq(longint num, longint den, inout bit ov);
    logic [127:0] q;
    if (den == 0) begin
      ov = 1;
      return 0;
    end
    q = {44'b0, umag(num), 20'b0} / {64'b0, umag(den)};
    if (q[127:64] != 0) begin
      ov = 1;
      return 0;
    end
    return fit(q[63:0], (num < 0) != (den < 0), ov);
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] n);
    logic [63:0] r, c;
    r = 0;
    for (int k = 63; k >= 0; k--) begin
      c = r | (64'd1 << k);
      if ({64'b0, c} * {64'b0, c} <= n) r = c;
    end
    return r;
  endfunction

  // Path length from a source to edge point t
  function automatic longint path_len(longint px, longint py, longint d, longint t);
    logic [127:0] n;
    logic [63:0]  mx, my;
    mx = umag(px - t);
    my = umag(py);
    n  = {64'b0, mx} * {64'b0, mx} + {64'b0, my} * {64'b0, my};
    return longint'(isqrt(n)) + d;
  endfunction

  // Bisector point and ownership; queues the pieces of one query
  function automatic void split_segment(query_t it);
    longint s, e, x1, y1, d1, x2, y2, d2, alpha, beta, bb, n1, n2, gamma;
    longint a, b, c, t, ac, disc, x, v1, v2, sq, num;
    bit     ov, cut, first;
    logic [63:0] ep;
    piece_t pc;
    s = it.seg_s; e = it.seg_e;
    x1 = it.x1; y1 = it.y1; d1 = longint'(it.d1);
    x2 = it.x2; y2 = it.y2; d2 = longint'(it.d2);
    ep = 64'(tol_eps);
    ov = 0; cut = 0; x = 0;
    alpha = x2 - x1;
    beta  = d2 - d1;
    bb    = mulq(beta, beta, ov);
    n1    = addq(mulq(x1, x1, ov), mulq(y1, y1, ov), ov);
    n2    = addq(mulq(x2, x2, ov), mulq(y2, y2, ov), ov);
    gamma = addq(addq(n1, -n2, ov), -bb, ov);
    a     = addq(mulq(alpha, alpha, ov), -bb, ov);
    t     = mulq(x2, bb, ov);
    b     = addq(mulq(gamma, alpha, ov), addq(t, t, ov), ov);
    c     = addq(quarter(mulq(gamma, gamma, ov)), -mulq(n2, bb, ov), ov);
    ac    = mulq(a, c, ov);
    ac    = addq(ac, ac, ov);
    ac    = addq(ac, ac, ov);
    disc  = addq(mulq(b, b, ov), -ac, ov);
    if (!ov && disc >= 0 && !(umag(b) < ep && umag(c) < ep)) begin
      if (umag(a) < ep) begin
        x = divq(-c, b, ov);
      end else begin
        sq  = longint'(isqrt({44'b0, disc, 20'b0}));
        num = a < 0 ? addq(-b, -sq, ov) : addq(-b, sq, ov);
        x   = divq(num, addq(a, a, ov), ov);
      end
      cut = !ov && x > s && x < e;
    end
    v1 = path_len(x1, y1, d1, s);
    v2 = path_len(x2, y2, d2, s);
    if (cut) begin
      first = v1 < v2 ? 1'b0 : 1'b1;
      pc = '{CW'(s), CW'(x), first, 1'b0};
      expect_piece(pc);
      pc = '{CW'(x), CW'(e), !first, 1'b1};
      expect_piece(pc);
      n_splits++;
      return;
    end
    // near-tie at the start: decide at the far end
    if (umag(v1 - v2) < ep) begin
      v1 = path_len(x1, y1, d1, e);
      v2 = path_len(x2, y2, d2, e);
    end
    pc = '{CW'(s), CW'(e), v2 < v1, 1'b1};
    expect_piece(pc);
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Driver: a transaction completes on start && !busy
  always @(posedge clk) begin
    query_t nx;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        split_segment('{in_seg_start, in_seg_end, in_src1_x, in_src1_y, in_src1_dist,
                        in_src2_x, in_src2_y, in_src2_dist});
        n_queries++;
        gap_left = pick_gap();
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        nx = pending_q.pop_front();
        in_seg_start <= nx.seg_s;
        in_seg_end   <= nx.seg_e;
        in_src1_x    <= nx.x1;
        in_src1_y    <= nx.y1;
        in_src1_dist <= nx.d1;
        in_src2_x    <= nx.x2;
        in_src2_y    <= nx.y2;
        in_src2_dist <= nx.d2;
        start        <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each strobe must match the oldest queued piece
  always @(posedge clk) begin
    piece_t ex;
    if (rst_n && out_strobe) begin
      n_pieces++;
      if (piece_q.size() == 0) begin
        $error("unexpected piece start=%h end=%h", out_piece_start, out_piece_end);
        n_fail++;
      end else begin
        ex = piece_q.pop_front();
        if (out_piece_start !== ex.p_start) begin
          $error("piece_start exp %h got %h", ex.p_start, out_piece_start);
          n_fail++;
        end
        if (out_piece_end !== ex.p_end) begin
          $error("piece_end exp %h got %h", ex.p_end, out_piece_end);
          n_fail++;
        end
        if (out_owner !== ex.owner) begin
          $error("owner exp %0d got %0d", ex.owner, out_owner);
          n_fail++;
        end
        if (out_last_piece !== ex.last) begin
          $error("last_piece exp %0d got %0d", ex.last, out_last_piece);
          n_fail++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("** geodesic_source_bisector: FAILED **");
      $finish;
    end
  end

  function automatic logic [CW-1:0] rnd_val(int lim_bits);
    logic [CW-1:0] v;
    v = $urandom();
    if (lim_bits >= CW) return v;
    return CW'($signed(v) >>> (CW - lim_bits));
  endfunction

  function automatic query_t rnd_query();
    query_t q;
    logic signed [CW-1:0] tmp, dl;
    int k, w;
    k = $urandom_range(99);
    w = $urandom_range(24, 19);
    q.x1 = rnd_val(w); q.y1 = rnd_val(w);
    q.x2 = rnd_val(w); q.y2 = rnd_val(w);
    q.d1 = (CW-1)'(rnd_val(w - 1) & 32'h7fff_ffff);
    q.d2 = (CW-1)'(rnd_val(w - 1) & 32'h7fff_ffff);
    q.seg_s = rnd_val(w + 1);
    q.seg_e = rnd_val(w + 1);
    if (q.seg_s > q.seg_e && k < 92) begin
      tmp = q.seg_s; q.seg_s = q.seg_e; q.seg_e = tmp;
    end
    if (k >= 60 && k < 72) begin
      // leading coefficient near zero: d2-d1 exceeds x2-x1 by at most 2
      dl = $urandom_range(1 << (w - 2));
      q.x2 = q.x1 + dl;
      q.d1 = (CW-1)'(32'(1) << (w - 2));
      q.d2 = q.d1 + (CW-1)'(dl + $urandom_range(2));
    end else if (k >= 72 && k < 80) begin
      q.x2 = q.x1; q.y2 = ($urandom_range(1)) ? q.y1 : -q.y1; q.d2 = q.d1;
    end else if (k >= 80) begin
      q.x1 = $urandom(); q.y1 = $urandom(); q.x2 = $urandom(); q.y2 = $urandom();
      q.d1 = (CW-1)'($urandom()); q.d2 = (CW-1)'($urandom());
      q.seg_s = $urandom(); q.seg_e = $urandom();
    end
    return q;
  endfunction

  task automatic drain(int extra);
    while (pending_q.size() > 0 || start || gap_left > 0 || piece_q.size() > 0)
      @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_eps(logic [EPS_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tol_eps = v;
  endtask

  localparam logic signed [CW-1:0] ONE = 32'sh0010_0000;
  localparam logic signed [CW-1:0] MX  = 32'sh7fff_ffff;
  localparam logic signed [CW-1:0] MN  = 32'sh8000_0000;

  initial begin
    logic [EPS_W-1:0] eps_set[6];
    eps_set = '{21'd1, 21'd0, 21'd1048576, 21'h1fffff, 21'd0, 21'd1};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, degenerate, linear, ties, clean split, bad segment
    enqueue_query('{0, 0, 0, 0, 0, 0, 0, 0});
    enqueue_query('{MN, MX, MX, MX, 31'h7fffffff, MN, MN, 31'h7fffffff});
    enqueue_query('{MX, MN, MN, MN, 0, MX, MX, 0});
    enqueue_query('{-2*ONE, 2*ONE, -ONE, ONE, 0, ONE, ONE, 0});
    enqueue_query('{-2*ONE, 2*ONE, ONE, ONE, 0, -ONE, ONE, 0});
    enqueue_query('{2*ONE, -2*ONE, -ONE, ONE, 0, ONE, ONE, 0});
    enqueue_query('{-2*ONE, 2*ONE, 0, ONE, 0, 0, ONE, 0});
    enqueue_query('{-2*ONE, 2*ONE, 0, ONE, ONE, ONE, ONE, 31'(2*ONE)});
    enqueue_query('{-4*ONE, 4*ONE, 0, 0, 0, ONE, 0, 31'(ONE/2)});
    enqueue_query('{-4*ONE, 4*ONE, 0, ONE, 0, 0, -ONE, 0});
    enqueue_query('{-4*ONE, 4*ONE, -ONE, 0, 0, ONE, 0, 31'(4*ONE)});
    enqueue_query('{0, 2*ONE, -ONE, ONE, 0, ONE, ONE, 0});
    enqueue_query('{-ONE, ONE, -ONE, 0, 0, ONE, 0, 0});
    enqueue_query('{-3*ONE, 3*ONE, -2*ONE, 3*ONE, 31'(ONE), 2*ONE, ONE, 0});
    enqueue_query('{ONE, ONE, -ONE, ONE, 0, ONE, ONE, 0});

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_eps(ph == 4 ? EPS_W'($urandom_range(4096)) : eps_set[ph]);
      no_gaps = (ph == 2);
      for (int i = 0; i < 205; i++) enqueue_query(rnd_query());
      // pause the sender until every piece is back
      drain(DRAIN_WAIT);
    end

    $display("ran %0d queries over 6 tolerance settings: %0d split, %0d pieces checked",
             n_queries, n_splits, n_pieces);
    if (n_fail == 0) begin
      $display("** geodesic_source_bisector: PASSED **");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("** geodesic_source_bisector: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/gsb_pkg.sv
rtl/core/geodesic_source_bisector.sv
tb/sv/tb_top.sv
